FILE: sv/bpsd_pkg.sv
// bpsd_pkg: shared constants, result codes and the queue item type
// for the bmp pixel stream decoder; no dependencies
package bpsd_pkg;

    // default image size limit
    localparam int MAX_DIM_DEF = 2048;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;
    localparam int KIND_W    = 2;
    localparam int PIX_W     = 11;
    localparam int COLOR_W   = 32;

    // header layout
    localparam logic [7:0] MAGIC_B   = 8'h42;
    localparam logic [7:0] MAGIC_M   = 8'h4D;
    localparam logic [5:0] OFF_MAG0  = 6'd0;
    localparam logic [5:0] OFF_MAG1  = 6'd1;
    localparam logic [5:0] OFF_WIDTH = 6'h12;
    localparam logic [5:0] OFF_HGT   = 6'h16;
    localparam logic [5:0] OFF_DEPTH = 6'h1C;
    localparam logic [5:0] HDR_LAST  = 6'd53;

    // supported pixel depths
    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOT_BMP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_DEPTH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_SIZE  = 2'd3;

    // one result item as it travels from the parser to the output stage
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COLOR_W-1:0] pixel_color;
        logic [PIX_W-1:0]   pixel_row;
        logic [PIX_W-1:0]   pixel_col;
        logic               last_pixel;
    } item_t;

endpackage

FILE: sv/bpsd_front.sv
// bpsd_front: byte parser, header capture, pixel assembly and position counters
// depends on bpsd_pkg
module bpsd_front #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_start,
    output logic                in_ready,
    input  logic                q_space,
    output logic                push,
    output bpsd_pkg::item_t     push_item
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXEL  = 2'd1;
    localparam logic [1:0] PH_PAD    = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [5:0]       off_reg, off_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      depth_reg, depth_next;
    logic [23:0]      pix_reg, pix_next;
    logic [1:0]       bip_reg, bip_next;
    logic [1:0]       pad_reg, pad_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;

    logic             accept;
    logic [1:0]       eff_phase;
    logic [5:0]       eff_off;
    logic [31:0]      eff_width, eff_height;
    logic [15:0]      eff_depth;
    logic             res;
    bpsd_pkg::item_t  item;
    logic [DIM_W-1:0] w_lo, h_lo, frow;
    logic             bpp4, done_pix, last;
    logic [23:0]      pix_new;
    logic [7:0]       alpha;

    function automatic logic dim_bad(input logic [31:0] v);
        dim_bad = (v == 32'd0) || v[31] || (v > 32'(MAX_DIM));
    endfunction

    assign in_ready  = q_space;
    assign accept    = in_valid && q_space;
    assign push      = accept && res;
    assign push_item = item;

    always_comb begin
        // a start marker restarts the parser before the byte is used
        eff_phase  = in_start ? PH_HEADER : phase_reg;
        eff_off    = in_start ? 6'd0 : off_reg;
        eff_width  = in_start ? 32'd0 : width_reg;
        eff_height = in_start ? 32'd0 : height_reg;
        eff_depth  = in_start ? 16'd0 : depth_reg;

        phase_next  = eff_phase;
        off_next    = eff_off;
        width_next  = eff_width;
        height_next = eff_height;
        depth_next  = eff_depth;
        pix_next    = pix_reg;
        bip_next    = bip_reg;
        pad_next    = pad_reg;
        col_next    = col_reg;
        row_next    = row_reg;

        res  = 1'b0;
        item = '0;

        w_lo     = width_reg[DIM_W-1:0];
        h_lo     = height_reg[DIM_W-1:0];
        frow     = h_lo - {{(DIM_W-1){1'b0}}, 1'b1} - row_reg;
        bpp4     = (depth_reg == bpsd_pkg::DEPTH_32);
        done_pix = bpp4 ? (bip_reg == 2'd3) : (bip_reg == 2'd2);
        last     = (row_reg == h_lo - {{(DIM_W-1){1'b0}}, 1'b1})
                && (col_reg == w_lo - {{(DIM_W-1){1'b0}}, 1'b1});
        pix_new  = pix_reg;
        alpha    = 8'd0;
        case (bip_reg)
            2'd0: pix_new[7:0]   = in_byte;
            2'd1: pix_new[15:8]  = in_byte;
            2'd2: pix_new[23:16] = in_byte;
            default: alpha       = in_byte;
        endcase

        case (eff_phase)
            PH_HEADER: begin
                if ((eff_off == bpsd_pkg::OFF_MAG0 && in_byte != bpsd_pkg::MAGIC_B)
                        || (eff_off == bpsd_pkg::OFF_MAG1 && in_byte != bpsd_pkg::MAGIC_M)) begin
                    res        = 1'b1;
                    item.kind  = bpsd_pkg::KIND_NOT_BMP;
                    phase_next = PH_HALT;
                end else if (eff_off >= bpsd_pkg::HDR_LAST) begin
                    if (eff_depth != bpsd_pkg::DEPTH_24 && eff_depth != bpsd_pkg::DEPTH_32) begin
                        res        = 1'b1;
                        item.kind  = bpsd_pkg::KIND_BAD_DEPTH;
                        phase_next = PH_HALT;
                    end else if (dim_bad(eff_width) || dim_bad(eff_height)) begin
                        res        = 1'b1;
                        item.kind  = bpsd_pkg::KIND_BAD_SIZE;
                        phase_next = PH_HALT;
                    end else begin
                        phase_next = PH_PIXEL;
                        pix_next   = 24'd0;
                        bip_next   = 2'd0;
                        col_next   = '0;
                        row_next   = '0;
                    end
                end else begin
                    // little-endian capture of width, height and depth
                    case (eff_off)
                        bpsd_pkg::OFF_WIDTH:         width_next[7:0]   = in_byte;
                        bpsd_pkg::OFF_WIDTH + 6'd1:  width_next[15:8]  = in_byte;
                        bpsd_pkg::OFF_WIDTH + 6'd2:  width_next[23:16] = in_byte;
                        bpsd_pkg::OFF_WIDTH + 6'd3:  width_next[31:24] = in_byte;
                        bpsd_pkg::OFF_HGT:           height_next[7:0]   = in_byte;
                        bpsd_pkg::OFF_HGT + 6'd1:    height_next[15:8]  = in_byte;
                        bpsd_pkg::OFF_HGT + 6'd2:    height_next[23:16] = in_byte;
                        bpsd_pkg::OFF_HGT + 6'd3:    height_next[31:24] = in_byte;
                        bpsd_pkg::OFF_DEPTH:         depth_next[7:0]   = in_byte;
                        bpsd_pkg::OFF_DEPTH + 6'd1:  depth_next[15:8]  = in_byte;
                        default: ;
                    endcase
                    off_next = eff_off + 6'd1;
                end
            end
            PH_PAD: begin
                pad_next = pad_reg - 2'd1;
                if (pad_reg == 2'd1) begin
                    phase_next = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                if (!done_pix) begin
                    pix_next = pix_new;
                    bip_next = bip_reg + 2'd1;
                end else begin
                    res              = 1'b1;
                    item.kind        = bpsd_pkg::KIND_PIXEL;
                    item.pixel_color = {alpha, pix_new};
                    item.pixel_row   = bpsd_pkg::PIX_W'(frow);
                    item.pixel_col   = bpsd_pkg::PIX_W'(col_reg);
                    item.last_pixel  = last;
                    pix_next         = 24'd0;
                    bip_next         = 2'd0;
                    col_next         = col_reg + {{(DIM_W-1){1'b0}}, 1'b1};
                    if (last) begin
                        phase_next = PH_HALT;
                    end else if (col_reg == w_lo - {{(DIM_W-1){1'b0}}, 1'b1}) begin
                        col_next = '0;
                        row_next = row_reg + {{(DIM_W-1){1'b0}}, 1'b1};
                        // 24-bit rows pad by width mod 4, 32-bit rows never pad
                        if (!bpp4 && width_reg[1:0] != 2'd0) begin
                            pad_next   = width_reg[1:0];
                            phase_next = PH_PAD;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            off_reg    <= 6'd0;
            width_reg  <= 32'd0;
            height_reg <= 32'd0;
            depth_reg  <= 16'd0;
            pix_reg    <= 24'd0;
            bip_reg    <= 2'd0;
            pad_reg    <= 2'd0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            pix_reg    <= pix_next;
            bip_reg    <= bip_next;
            pad_reg    <= pad_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // the parser halts after the final pixel
    a_halt_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_item.last_pixel |=> phase_reg == PH_HALT)
        else $error("parser not halted after last pixel");

    // any error result halts the parser
    a_halt_after_err: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_item.kind != bpsd_pkg::KIND_PIXEL |=> phase_reg == PH_HALT)
        else $error("parser not halted after error");

    // padding phase always has bytes left to skip
    a_pad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> pad_reg != 2'd0)
        else $error("padding phase with no bytes left");

endmodule

FILE: sv/bpsd_queue.sv
// bpsd_queue: two-entry item queue between the parser and the output stage
// depends on bpsd_pkg
module bpsd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bpsd_pkg::item_t push_item,
    output logic            space,
    input  logic            pop_ready,
    output logic            head_valid,
    output bpsd_pkg::item_t head_item
);

    logic [1:0]      count_reg, count_next;
    bpsd_pkg::item_t q0_reg, q1_reg;
    logic            pop;

    assign space      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = q0_reg;
    assign pop        = head_valid && pop_ready;

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // payload shifts toward the head
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (count_reg == 2'd2) begin
                q0_reg <= q1_reg;
                if (push) begin
                    q1_reg <= push_item;
                end
            end else if (push) begin
                q0_reg <= push_item;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                q0_reg <= push_item;
            end else begin
                q1_reg <= push_item;
            end
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != 2'd2)
        else $error("push into full queue");

endmodule

FILE: sv/bpsd_out.sv
// bpsd_out: output register stage driving the result stream
// depends on bpsd_pkg
module bpsd_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             head_valid,
    input  bpsd_pkg::item_t                  head_item,
    output logic                             take,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bpsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [bpsd_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                             m_axis_tlast
);

    logic            valid_reg;
    bpsd_pkg::item_t item_reg;

    assign take = !valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && head_valid) begin
            item_reg <= head_item;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = item_reg.kind;
    assign m_axis_tlast  = item_reg.last_pixel;
    assign m_axis_tdata  = {2'b00, item_reg.pixel_col, item_reg.pixel_row,
                            item_reg.pixel_color};

endmodule

FILE: sv/bmp_pixel_stream_decoder.sv
// bmp_pixel_stream_decoder: top level, byte-serial bmp header parser and pixel decoder
// depends on bpsd_pkg, bpsd_front, bpsd_queue, bpsd_out
// path: an accepted file byte's result is registered in the queue, then in the output register, before m_axis_tvalid
// throughput: one file byte per cycle while the queue has space, set by the single-byte parser step
// reset: synchronous active-low aresetn clears the parser to the header phase
// and empties the queue and output register; the first byte after reset is offset 0
module bmp_pixel_stream_decoder #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // file byte input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bpsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] file_byte
    input  logic                             s_axis_tuser,  // [0] file_start
    // decoded result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] pixel_color, [42:32] pixel_row, [53:43] pixel_col, [55:54] zero
    output logic [bpsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [bpsd_pkg::KIND_W-1:0]      m_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tlast   // last_pixel
);

    // front to queue
    logic            push;
    bpsd_pkg::item_t push_item;
    logic            q_space;

    // queue to output stage
    logic            head_valid;
    bpsd_pkg::item_t head_item;
    logic            take;

    // parser: accepts bytes, captures header, assembles pixels and counts position
    bpsd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_start  (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .q_space   (q_space),
        .push      (push),
        .push_item (push_item)
    );

    // short queue so the parser keeps going while the output side stalls
    bpsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .space      (q_space),
        .pop_ready  (take),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // registered output stage
    bpsd_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
